// File: src/qdec_pkg.sv
// Shared types, constants and a helper function of the quadrature decoder.
`default_nettype none

package qdec_pkg;

    // Number of channel slots the stream format carries.
    localparam int SLOTS = 5;
    localparam int PINS = 2 * SLOTS;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF = 5;
    localparam int COUNT_WIDTH_DEF = 32;

    // Field widths of the stream items.
    localparam int PINS_LOW_W = 8;
    localparam int PINS_HIGH_W = 2;
    localparam int STAMP_W = 32;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_FIELDS_W = 3 * SLOTS + PINS + VALUE_W;
    localparam int M_TDATA_W = 64;
    localparam int M_PAD_W = M_TDATA_W - M_FIELDS_W;

    // Item kinds carried in tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // First read index of each counter bank.
    localparam int IDX_FWD = 0;
    localparam int IDX_BWD = 5;
    localparam int IDX_ERR = 10;
    localparam int IDX_RISE = 15;
    localparam int IDX_STAMP = 25;

    // Per-channel tracking state.
    typedef enum logic [2:0] {
        ST_INIT    = 3'b001,
        ST_TRACK   = 3'b010,
        ST_RECOVER = 3'b100
    } lane_state_t;

    // What one lane found on the current sample; rise[1] is pin A, rise[0] is pin B.
    typedef struct packed {
        logic       fwd;
        logic       bwd;
        logic       err;
        logic [1:0] rise;
    } lane_flags_t;

    // Position in the forward Gray cycle LL -> HL -> HH -> LH for pins {A, B}.
    function automatic logic [1:0] gray_pos(input logic [1:0] pins);
        logic [1:0] pos;
        case (pins)
            2'b00:   pos = 2'd0;
            2'b01:   pos = 2'd3;
            2'b10:   pos = 2'd1;
            default: pos = 2'd2;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

// File: src/qdec_lane.sv
// One quadrature channel: Gray-code tracker, step and error counters, per-pin edge statistics.
`default_nettype none

module qdec_lane #(
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  accept,
    input  wire logic                                  sample,
    input  wire logic [1:0]                            pins,
    input  wire logic [qdec_pkg::STAMP_W-1:0]          stamp,
    output qdec_pkg::lane_flags_t                      flags,
    output logic [COUNT_WIDTH-1:0]                     fwd_cnt,
    output logic [COUNT_WIDTH-1:0]                     bwd_cnt,
    output logic [COUNT_WIDTH-1:0]                     err_cnt,
    output logic [1:0][COUNT_WIDTH-1:0]                rise_cnt,
    output logic [1:0][qdec_pkg::STAMP_W-1:0]          stamp_val
);
    import qdec_pkg::*;

    lane_state_t                   state_reg, state_next;
    logic [1:0]                    last_reg;
    logic [COUNT_WIDTH-1:0]        fwd_reg, bwd_reg, err_reg;
    logic [1:0][COUNT_WIDTH-1:0]   rise_reg;
    logic [1:0][STAMP_W-1:0]       stamp_reg;
    logic [1:0]                    step;
    lane_flags_t                   found;
    logic                          update;

    assign update = accept && sample;
    assign step = gray_pos(pins) - gray_pos(last_reg);

    // While tracking, last_reg also holds the settled position.
    always_comb
    begin
        state_next = state_reg;
        found = '0;
        unique case (state_reg)
            ST_TRACK:
            begin
                found.rise = pins & ~last_reg;
                case (step)
                    2'd1:    found.fwd = 1'b1;
                    2'd3:    found.bwd = 1'b1;
                    2'd2:
                    begin
                        found.err = 1'b1;
                        state_next = ST_RECOVER;
                    end
                    default: state_next = ST_TRACK;
                endcase
            end
            ST_RECOVER:
            begin
                found.rise = pins & ~last_reg;
                state_next = ST_TRACK;
            end
            default: state_next = ST_TRACK;
        endcase
        if (!sample)
        begin
            found = '0;
        end
    end

    assign flags = found;

    // Edge counter and stamp index 0 belong to pin A, index 1 to pin B.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            last_reg  <= '0;
            fwd_reg   <= '0;
            bwd_reg   <= '0;
            err_reg   <= '0;
            rise_reg  <= '0;
            stamp_reg <= '0;
        end
        else if (update)
        begin
            state_reg <= state_next;
            last_reg  <= pins;
            if (found.fwd)
            begin
                fwd_reg <= fwd_reg + COUNT_WIDTH'(1);
            end
            if (found.bwd)
            begin
                bwd_reg <= bwd_reg + COUNT_WIDTH'(1);
            end
            if (found.err)
            begin
                err_reg <= err_reg + COUNT_WIDTH'(1);
            end
            for (int p = 0; p < 2; p++)
            begin
                if (found.rise[1 - p])
                begin
                    rise_reg[p]  <= rise_reg[p] + COUNT_WIDTH'(1);
                    stamp_reg[p] <= stamp;
                end
            end
        end
    end

    assign fwd_cnt   = fwd_reg;
    assign bwd_cnt   = bwd_reg;
    assign err_cnt   = err_reg;
    assign rise_cnt  = rise_reg;
    assign stamp_val = stamp_reg;

    // A sample yields at most one kind of step.
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({found.fwd, found.bwd, found.err}))
        else $error("lane reported more than one step kind");

    // An illegal jump always leads into recovery.
    a_err_recover: assert property (@(posedge clk) disable iff (!rst_n)
        update && found.err |=> state_reg == ST_RECOVER)
        else $error("lane did not enter recovery after a jump");

    // A counted step settles on the new pins.
    a_step_settle: assert property (@(posedge clk) disable iff (!rst_n)
        update && (found.fwd || found.bwd) |=> state_reg == ST_TRACK && last_reg == $past(pins))
        else $error("lane did not settle after a step");

    // Nothing is reported on the first sample after reset.
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> found == '0)
        else $error("lane reported activity on its first sample");

endmodule

`default_nettype wire

// File: src/qdec_merge.sv
// Merging stage: combines the lane flags into masks, selects a counter and holds the result.
`default_nettype none

module qdec_merge #(
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           in_valid,
    output logic                                                in_ready,
    output logic                                                accept,
    input  wire logic                                           opcode,
    input  wire logic [qdec_pkg::INDEX_W-1:0]                   read_index,
    input  wire qdec_pkg::lane_flags_t [qdec_pkg::SLOTS-1:0]    flags,
    input  wire logic [qdec_pkg::SLOTS-1:0][COUNT_WIDTH-1:0]    fwd_cnt,
    input  wire logic [qdec_pkg::SLOTS-1:0][COUNT_WIDTH-1:0]    bwd_cnt,
    input  wire logic [qdec_pkg::SLOTS-1:0][COUNT_WIDTH-1:0]    err_cnt,
    input  wire logic [qdec_pkg::PINS-1:0][COUNT_WIDTH-1:0]     rise_cnt,
    input  wire logic [qdec_pkg::PINS-1:0][qdec_pkg::STAMP_W-1:0] stamp_val,
    output logic                                                out_valid,
    input  wire logic                                           out_ready,
    output logic [qdec_pkg::M_TDATA_W-1:0]                      out_data
);
    import qdec_pkg::*;

    logic                   valid_reg;
    logic [M_TDATA_W-1:0]   data_reg, data_next;
    logic [SLOTS-1:0]       fwd_mask, bwd_mask, err_mask;
    logic [PINS-1:0]        rise_mask;
    logic [VALUE_W-1:0]     selected, read_value;

    assign in_ready = !valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            fwd_mask[i]      = flags[i].fwd;
            bwd_mask[i]      = flags[i].bwd;
            err_mask[i]      = flags[i].err;
            rise_mask[2*i]   = flags[i].rise[1];
            rise_mask[2*i+1] = flags[i].rise[0];
        end
    end

    // Compare-and-select over all counters; indexes past the last bank give zero.
    always_comb
    begin
        selected = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (read_index == INDEX_W'(IDX_FWD + i))
            begin
                selected = VALUE_W'(fwd_cnt[i]);
            end
            if (read_index == INDEX_W'(IDX_BWD + i))
            begin
                selected = VALUE_W'(bwd_cnt[i]);
            end
            if (read_index == INDEX_W'(IDX_ERR + i))
            begin
                selected = VALUE_W'(err_cnt[i]);
            end
        end
        for (int i = 0; i < PINS; i++)
        begin
            if (read_index == INDEX_W'(IDX_RISE + i))
            begin
                selected = VALUE_W'(rise_cnt[i]);
            end
            if (read_index == INDEX_W'(IDX_STAMP + i))
            begin
                selected = stamp_val[i];
            end
        end
    end

    assign read_value = (opcode == OP_READ) ? selected : '0;
    assign data_next = {{M_PAD_W{1'b0}}, read_value, rise_mask, err_mask, bwd_mask, fwd_mask};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// File: src/multi_channel_quadrature_decoder.sv
// Top level of the multi-channel quadrature decoder: stream ports, channel lanes and merging stage.
`default_nettype none

// Decodes up to five quadrature encoder channels from a stream of pin samples. Each slave
// transfer is either a pin sample (tuser = 0) or a counter read (tuser = 1), and every
// accepted transfer produces exactly one master transfer. Channels 0 to 3 take their pin
// pairs from pins_low, highest pair first, and channel 4 takes pins_high; in each pair the
// upper bit is pin A. A channel counts a forward step along LL, HL, HH, LH and a backward
// step along the reverse order. A change of both pins at once counts an error and puts the
// channel into recovery; the following sample is then taken as the new position without a
// step. Every 0-to-1 change of a pin counts a rising edge and stores the sample's timestamp.
// The first sample after reset only sets the position. The result of a sample carries the
// per-channel step and error masks and the per-pin rise mask, with read_value zero; the
// result of a read carries zero masks and the counter that read_index selects (0-4 forward,
// 5-9 backward, 10-14 error, 15-24 rise counters, 25-34 last rise timestamps, anything
// else reads as zero). Counters wrap at COUNT_WIDTH bits and read back as their low 32
// bits. A transfer is taken every clock cycle unless a full output register is stalled: all
// channels update in parallel in the cycle a sample is accepted, and a read in the very next
// cycle already sees the new counts. The result appears in the cycle after acceptance in
// an output register, and the block keeps accepting while that register drains, so
// throughput is one transfer per cycle whenever the master side is ready. Channels at or
// above CHANNELS are left out; their mask bits are zero and their counters read as zero.

module multi_channel_quadrature_decoder #(
    parameter int CHANNELS = qdec_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // From bit 0: pins_low[7:0], pins_high[9:8], timestamp[41:10], read_index[47:42].
    input  wire logic [qdec_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // From bit 0: opcode[0].
    input  wire logic [qdec_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // From bit 0: forward_mask[4:0], backward_mask[9:5], error_mask[14:10],
    // rise_mask[24:15], read_value[56:25], zero fill[63:57].
    output logic [qdec_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import qdec_pkg::*;

    logic [PINS_LOW_W-1:0]              pins_low;
    logic [PINS_HIGH_W-1:0]             pins_high;
    logic [STAMP_W-1:0]                 timestamp;
    logic [INDEX_W-1:0]                 read_index;
    logic                               opcode;
    logic                               accept;
    logic                               sample;

    lane_flags_t [SLOTS-1:0]            flags;
    logic [SLOTS-1:0][COUNT_WIDTH-1:0]  fwd_cnt, bwd_cnt, err_cnt;
    logic [PINS-1:0][COUNT_WIDTH-1:0]   rise_cnt;
    logic [PINS-1:0][STAMP_W-1:0]       stamp_val;

    // Unpack the slave transfer.
    assign pins_low   = s_axis_tdata[PINS_LOW_W-1:0];
    assign pins_high  = s_axis_tdata[PINS_LOW_W +: PINS_HIGH_W];
    assign timestamp  = s_axis_tdata[PINS_LOW_W + PINS_HIGH_W +: STAMP_W];
    assign read_index = s_axis_tdata[PINS_LOW_W + PINS_HIGH_W + STAMP_W +: INDEX_W];
    assign opcode     = s_axis_tuser[0];
    assign sample     = (opcode == OP_SAMPLE);

    // One lane per configured channel; the remaining slots stay quiet and read as zero.
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_lane
        if (j < CHANNELS)
        begin : g_on
            logic [1:0] pins;

            if (j < SLOTS - 1)
            begin : g_low
                assign pins = pins_low[PINS_LOW_W - 1 - 2*j -: 2];
            end
            else
            begin : g_high
                assign pins = pins_high;
            end

            qdec_lane #(
                .COUNT_WIDTH(COUNT_WIDTH)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .accept    (accept),
                .sample    (sample),
                .pins      (pins),
                .stamp     (timestamp),
                .flags     (flags[j]),
                .fwd_cnt   (fwd_cnt[j]),
                .bwd_cnt   (bwd_cnt[j]),
                .err_cnt   (err_cnt[j]),
                .rise_cnt  (rise_cnt[2*j +: 2]),
                .stamp_val (stamp_val[2*j +: 2])
            );
        end
        else
        begin : g_off
            assign flags[j]            = '0;
            assign fwd_cnt[j]          = '0;
            assign bwd_cnt[j]          = '0;
            assign err_cnt[j]          = '0;
            assign rise_cnt[2*j +: 2]  = '0;
            assign stamp_val[2*j +: 2] = '0;
        end
    end

    qdec_merge #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .accept     (accept),
        .opcode     (opcode),
        .read_index (read_index),
        .flags      (flags),
        .fwd_cnt    (fwd_cnt),
        .bwd_cnt    (bwd_cnt),
        .err_cnt    (err_cnt),
        .rise_cnt   (rise_cnt),
        .stamp_val  (stamp_val),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: tb/sv/qdec_count_checker.sv
`timescale 1ns / 100ps
// Checker that tracks the decoder's channels and counters and compares every result transfer.
module qdec_count_checker #(
    parameter int CHANNELS = qdec_pkg::CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [qdec_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [qdec_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [qdec_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                               fail_count,
    output int                               pending,
    output int                               compared
);

    localparam int SLOTS = qdec_pkg::SLOTS;
    localparam int PINS = qdec_pkg::PINS;

    // Pin pairs written as {A, B}.
    localparam logic [1:0] PINS_LL = 2'b00;
    localparam logic [1:0] PINS_LH = 2'b01;
    localparam logic [1:0] PINS_HL = 2'b10;
    localparam logic [1:0] PINS_HH = 2'b11;

    typedef enum logic [1:0] {
        TRK_FRESH,
        TRK_SETTLED,
        TRK_RECOVER
    } track_t;

    typedef struct packed {
        logic [4:0]  fwd;
        logic [4:0]  bwd;
        logic [4:0]  err;
        logic [9:0]  rise;
        logic [31:0] value;
    } decode_result_t;

    track_t         trk [SLOTS];
    logic [1:0]     prev_pins [SLOTS];
    logic [31:0]    fwd_total [SLOTS];
    logic [31:0]    bwd_total [SLOTS];
    logic [31:0]    err_total [SLOTS];
    logic [31:0]    rise_total [PINS];
    logic [31:0]    rise_stamp [PINS];
    decode_result_t expected_q [$];

    // Applies one input transfer to the tracked state and returns the result it must produce.
    function automatic decode_result_t decode_item(input logic op, input logic [47:0] data);
        decode_result_t res;
        logic [1:0]     now;
        logic [1:0]     old;
        logic [1:0]     rose;
        logic [5:0]     idx;
        int             j;
        res = '0;
        if (op == qdec_pkg::OP_READ) begin
            idx = data[47:42];
            if (idx < qdec_pkg::IDX_BWD)
                res.value = fwd_total[idx];
            else if (idx < qdec_pkg::IDX_ERR)
                res.value = bwd_total[idx - qdec_pkg::IDX_BWD];
            else if (idx < qdec_pkg::IDX_RISE)
                res.value = err_total[idx - qdec_pkg::IDX_ERR];
            else if (idx < qdec_pkg::IDX_STAMP)
                res.value = rise_total[idx - qdec_pkg::IDX_RISE];
            else if (idx < qdec_pkg::IDX_STAMP + PINS)
                res.value = rise_stamp[idx - qdec_pkg::IDX_STAMP];
        end
        else begin
            for (j = 0; j < CHANNELS && j < SLOTS; j++) begin
                now = (j < 4) ? data[7 - 2 * j -: 2] : data[9:8];
                old = prev_pins[j];
                if (trk[j] == TRK_FRESH) begin
                    trk[j] = TRK_SETTLED;
                end
                else begin
                    rose = now & ~old;
                    if (rose[1])
                    begin
                        res.rise[2 * j] = 1'b1;
                        rise_total[2 * j] += 1;
                        rise_stamp[2 * j] = data[41:10];
                    end
                    if (rose[0])
                    begin
                        res.rise[2 * j + 1] = 1'b1;
                        rise_total[2 * j + 1] += 1;
                        rise_stamp[2 * j + 1] = data[41:10];
                    end
                    if (trk[j] == TRK_RECOVER) begin
                        trk[j] = TRK_SETTLED;
                    end
                    else begin
                        case ({old, now})
                            {PINS_LL, PINS_HL}, {PINS_HL, PINS_HH},
                            {PINS_HH, PINS_LH}, {PINS_LH, PINS_LL}:
                            begin
                                res.fwd[j] = 1'b1;
                                fwd_total[j] += 1;
                            end
                            {PINS_HL, PINS_LL}, {PINS_HH, PINS_HL},
                            {PINS_LH, PINS_HH}, {PINS_LL, PINS_LH}:
                            begin
                                res.bwd[j] = 1'b1;
                                bwd_total[j] += 1;
                            end
                            {PINS_LL, PINS_HH}, {PINS_HH, PINS_LL},
                            {PINS_LH, PINS_HL}, {PINS_HL, PINS_LH}:
                            begin
                                res.err[j] = 1'b1;
                                err_total[j] += 1;
                                trk[j] = TRK_RECOVER;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                prev_pins[j] = now;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        decode_result_t exp_r;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                trk[i] = TRK_FRESH;
                prev_pins[i] = PINS_LL;
                fwd_total[i] = '0;
                bwd_total[i] = '0;
                err_total[i] = '0;
            end
            for (int i = 0; i < PINS; i++) begin
                rise_total[i] = '0;
                rise_stamp[i] = '0;
            end
            expected_q.delete();
            fail_count = 0;
            pending = 0;
            compared = 0;
        end
        else begin
            // Results leave before the same edge's input is applied, so pop first.
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else begin
                    exp_r = expected_q.pop_front();
                    check_field("forward_mask", exp_r.fwd, m_tdata[4:0]);
                    check_field("backward_mask", exp_r.bwd, m_tdata[9:5]);
                    check_field("error_mask", exp_r.err, m_tdata[14:10]);
                    check_field("rise_mask", exp_r.rise, m_tdata[24:15]);
                    check_field("read_value", exp_r.value, m_tdata[56:25]);
                    check_field("zero fill", '0, m_tdata[63:57]);
                    compared++;
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(decode_item(s_tuser[0], s_tdata));
            pending = expected_q.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the quadrature decoder testbench: clock, reset, stimulus, result backpressure and verdict.
module tb_top;

    localparam int CHANNELS = qdec_pkg::CHANNELS_DEF;
    localparam int RANDOM_ITEMS = 1350;

    // Forward Gray order of the pin pairs {A, B}: LL, HL, HH, LH.
    localparam logic [1:0] GRAY_CYCLE [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // From bit 0: pins_low[7:0], pins_high[9:8], timestamp[41:10], read_index[47:42].
    logic [47:0] s_axis_tdata = '0;
    // From bit 0: opcode[0].
    logic [0:0]  s_axis_tuser = qdec_pkg::OP_SAMPLE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // From bit 0: forward_mask[4:0], backward_mask[9:5], error_mask[14:10],
    // rise_mask[24:15], read_value[56:25], zero fill[63:57].
    logic [63:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          compared;
    int          sample_count = 0;
    int          read_count = 0;

    // When set, the matching side runs back to back with no gaps.
    bit          src_steady = 1'b0;
    bit          snk_steady = 1'b0;

    // Pins each channel of the random walk currently shows.
    logic [1:0]  walk_pins [5];
    logic [31:0] stamp_now = '0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    multi_channel_quadrature_decoder #(
        .CHANNELS   (CHANNELS),
        .COUNT_WIDTH(qdec_pkg::COUNT_WIDTH_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // The checker sees both streams, predicts every result and counts mismatches.
    qdec_count_checker #(
        .CHANNELS(CHANNELS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .fail_count(fail_count),
        .pending   (pending),
        .compared  (compared)
    );

    // Moves a pin pair the given number of places along the forward Gray order.
    // One place is a forward step, three a backward step and two a two-pin jump.
    function automatic logic [1:0] gray_step(input logic [1:0] pins, input int places);
        int k;
        int at;
        at = 0;
        for (k = 0; k < 4; k++) begin
            if (GRAY_CYCLE[k] == pins)
                at = k;
        end
        return GRAY_CYCLE[(at + places) % 4];
    endfunction

    // Offers one transfer to the decoder and returns at the falling edge after it is taken.
    // The task is entered at a falling edge, so every input change lands on one.
    task automatic send_item(input logic op, input logic [7:0] pins_low,
                             input logic [1:0] pins_high, input logic [31:0] stamp,
                             input logic [5:0] read_index);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {read_index, stamp, pins_high, pins_low};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (op == qdec_pkg::OP_READ)
            read_count++;
        else
            sample_count++;
    endtask

    // Result side: before each transfer it draws a stall, and now and then it switches to
    // a stretch where it is always ready.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                snk_steady = !snk_steady;
            stall = snk_steady ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial begin
        logic       op;
        logic [7:0] pins_low;
        logic [1:0] pins_high;
        logic [5:0] read_index;
        int         j;
        int         roll;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A read before any sample must see zero counters.
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_FWD);
        // The first sample only sets the position: all pins high, no counts, no rises.
        send_item(qdec_pkg::OP_SAMPLE, 8'hFF, 2'b11, 32'h0000_0000, 6'h00);
        // Both pins of every channel fall at once: an error on each channel.
        send_item(qdec_pkg::OP_SAMPLE, 8'h00, 2'b00, 32'h0000_0001, 6'h00);
        // Recovery sample: position adopted without a step, every pin counts a rise
        // against the error sample. The unused read_index bits are all set here.
        send_item(qdec_pkg::OP_SAMPLE, 8'hFF, 2'b11, 32'hFFFF_FFFF, 6'h3F);
        // A full forward and backward tour on all channels at once, including the
        // backward step from both pins high to only pin A high.
        send_item(qdec_pkg::OP_SAMPLE, 8'h55, 2'b01, 32'hAAAA_AAAA, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'h00, 2'b00, 32'h5555_5555, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'h55, 2'b01, 32'h0000_0010, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'hFF, 2'b11, 32'h0000_0011, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'hAA, 2'b10, 32'h0000_0012, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'h00, 2'b00, 32'h0000_0013, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'hAA, 2'b10, 32'h0000_0014, 6'h00);
        send_item(qdec_pkg::OP_SAMPLE, 8'hFF, 2'b11, 32'h0000_0015, 6'h00);
        // No pin changes at all.
        send_item(qdec_pkg::OP_SAMPLE, 8'hFF, 2'b11, 32'h0000_0016, 6'h00);
        // Mixed sample: channel 0 jumps, 1 steps back, 2 steps forward, 3 holds, 4 jumps.
        send_item(qdec_pkg::OP_SAMPLE, 8'h27, 2'b00, 32'h1234_5678, 6'h00);
        // Channels 0 and 4 recover, 1 and 2 jump between the one-pin-high states,
        // 3 steps forward.
        send_item(qdec_pkg::OP_SAMPLE, 8'h59, 2'b10, 32'h8765_4321, 6'h00);
        // Reads across every counter bank and past the last index. Pin fields on reads
        // must be ignored.
        send_item(qdec_pkg::OP_READ, 8'hFF, 2'b11, 32'hFFFF_FFFF, qdec_pkg::IDX_FWD + 4);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_BWD);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_ERR + 4);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_RISE);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_RISE + 9);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_STAMP);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, qdec_pkg::IDX_STAMP + 9);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, 6'd35);
        send_item(qdec_pkg::OP_READ, 8'h00, 2'b00, 32'h0, 6'd63);

        // The random walk starts from the pins of the last directed sample.
        walk_pins[0] = 2'b01;
        walk_pins[1] = 2'b01;
        walk_pins[2] = 2'b10;
        walk_pins[3] = 2'b01;
        walk_pins[4] = 2'b10;

        // Random part: mostly legal Gray walks with random direction per channel, some
        // two-pin jumps, about one sample in twelve of pure noise, and a quarter reads.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0)
                src_steady = !src_steady;
            if ($urandom_range(0, 15) == 0)
                stamp_now = $urandom;
            else
                stamp_now += $urandom_range(1, 500);
            pins_low = $urandom_range(0, 255);
            pins_high = $urandom_range(0, 3);
            read_index = 6'd0;
            if ($urandom_range(0, 3) == 0) begin
                op = qdec_pkg::OP_READ;
                if ($urandom_range(0, 9) == 0)
                    read_index = $urandom_range(35, 63);
                else
                    read_index = $urandom_range(0, 34);
            end
            else begin
                op = qdec_pkg::OP_SAMPLE;
                if ($urandom_range(0, 11) == 0) begin
                    // Noise: the random pins stand, and the walk continues from them.
                    for (j = 0; j < 4; j++)
                        walk_pins[j] = pins_low[7 - 2 * j -: 2];
                    walk_pins[4] = pins_high;
                end
                else begin
                    for (j = 0; j < 5; j++) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 40)
                            walk_pins[j] = gray_step(walk_pins[j], 1);
                        else if (roll < 70)
                            walk_pins[j] = gray_step(walk_pins[j], 3);
                        else if (roll >= 94)
                            walk_pins[j] = gray_step(walk_pins[j], 2);
                    end
                    pins_low = {walk_pins[0], walk_pins[1], walk_pins[2], walk_pins[3]};
                    pins_high = walk_pins[4];
                    if ($urandom_range(0, 7) == 0)
                        read_index = $urandom_range(0, 63);
                end
            end
            send_item(op, pins_low, pins_high, stamp_now, read_index);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every expected result must arrive, then a short quiet period in which
        // no stray transfer may appear.
        wait (pending == 0);
        repeat (20) @(posedge clk);

        $display("Covered %0d pin samples and %0d counter reads; %0d results compared.",
                 sample_count, read_count, compared);
        $display("Stimulus had Gray walks both ways, two-pin jumps with recovery, noise, "
                 , "and reads of every counter bank and past the last index.");
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a correct run takes well under a millisecond even with the longest stalls.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
